// ===== src/slfr_pkg.sv =====
`default_nettype none

package slfr_pkg;

  // Default console line capacity in characters.
  localparam int LINE_DEPTH_DEF = 64;

  // Fixed field widths.
  localparam int BYTE_W = 8;
  localparam int RIDX_W = 6;
  localparam int LEN_W  = 7;
  localparam int CFG_IDX_W = 3;

  // Frame sync pattern and console control characters.
  localparam logic [BYTE_W-1:0] SYNC_A = 8'hB5;
  localparam logic [BYTE_W-1:0] SYNC_B = 8'h43;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ID_STATE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_LED_A     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_LED_B     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_CONSOLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_TELEMETRY = 3'd4;

  // Input word kinds.
  typedef enum logic [1:0] {
    MODE_RX    = 2'd0,
    MODE_LEAVE = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_FRAME    = 3'd1,
    EV_ECHO     = 3'd2,
    EV_LINE     = 3'd3,
    EV_CONSOLE  = 3'd4,
    EV_OVERFLOW = 3'd5
  } ev_t;

  // Frame receiver phases.
  typedef enum logic [2:0] {
    PH_SYNC1     = 3'd0,
    PH_SYNC2     = 3'd1,
    PH_ID        = 3'd2,
    PH_LEN       = 3'd3,
    PH_PAY_FIRST = 3'd4,
    PH_PAY_REST  = 3'd5,
    PH_TRAILER   = 3'd6
  } phase_t;

endpackage

`default_nettype wire

// ===== src/slfr_line_mem.sv =====
`default_nettype none

module slfr_line_mem
  import slfr_pkg::*;
#(
  parameter int DEPTH = LINE_DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire               clk,
  input  wire               wr_en,
  input  wire [IDX_W-1:0]   wr_addr,
  input  wire [BYTE_W-1:0]  wr_data,
  input  wire               rd_en,
  input  wire [IDX_W-1:0]   rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  // Line store write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a write to the same entry in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/sync_length_frame_receiver_with_console_core.sv =====
`default_nettype none

// Channel   Direction  Fields (lowest bit first)
// s_axis    in         tuser: mode[1:0]; tdata: rx_byte[7:0], read_index[13:8]
// m_axis    out        tuser: event_res[2:0]; tdata: msg_id, echo_byte, line_length,
//                      line_char, flight_state, led_a, led_b, console_active,
//                      telemetry_request
// cfg       in         cfg_we, cfg_index, cfg_data (message id registers)
//
// One word is accepted per cycle while the result is not stalled; the input register takes it
// at the accepting edge, and its result is then loaded into the result register.
// The line store read is registered alongside the result.
// Reset is synchronous and clears all control and frame state; the line store is not
// cleared, since only entries below the line count are ever shown.
// A stalled result holds the pipeline; the input side keeps taking words while the
// input register is free to move.

module sync_length_frame_receiver_with_console_core
  import slfr_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  // mode[1:0]
  input  wire [1:0]           s_axis_tuser,
  // rx_byte[7:0], read_index[13:8], zero[15:14]
  input  wire [15:0]          s_axis_tdata,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  // event_res[2:0]
  output logic [2:0]          m_axis_tuser,
  // msg_id[7:0], echo_byte[15:8], line_length[22:16], line_char[30:23],
  // flight_state[38:31], led_a[39], led_b[40], console_active[41],
  // telemetry_request[42], zero[47:43]
  output logic [47:0]         m_axis_tdata,
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  input  wire                 cfg_we,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [BYTE_W-1:0]    cfg_data
);

  localparam int IDX_W = $clog2(LINE_DEPTH);
  localparam int CNT_W = $clog2(LINE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LINE_DEPTH);

  // Configuration registers.
  logic [BYTE_W-1:0] id_state;
  logic [BYTE_W-1:0] id_led_a;
  logic [BYTE_W-1:0] id_led_b;
  logic [BYTE_W-1:0] id_console;
  logic [BYTE_W-1:0] id_telemetry;

  // Input register.
  logic              s1_valid;
  logic [1:0]        s1_mode;
  logic [BYTE_W-1:0] s1_byte;
  logic [RIDX_W-1:0] s1_ridx;
  logic              s1_adv;

  // Receiver and console state.
  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] current_id, current_id_next;
  logic [BYTE_W-1:0] payload_left, payload_left_next;
  logic [BYTE_W-1:0] first_payload, first_payload_next;
  logic              has_payload, has_payload_next;
  logic [BYTE_W-1:0] flight_value, flight_value_next;
  logic [1:0]        led_levels, led_levels_next;
  logic              console_mode, console_mode_next;
  logic [CNT_W-1:0]  line_count, line_count_next;
  logic              line_done, line_done_next;

  // Per-word decode.
  logic [CNT_W-1:0]  line_base;
  logic [BYTE_W-1:0] payload_dec;
  logic              wr_en;
  ev_t               ev;
  logic              tele;
  logic [BYTE_W-1:0] echo;
  logic              frame_word;
  logic              console_word;

  // Result register.
  ev_t               out_ev;
  logic [BYTE_W-1:0] out_msg;
  logic [BYTE_W-1:0] out_echo;
  logic [LEN_W-1:0]  out_len;
  logic              out_char_ok;
  logic [BYTE_W-1:0] out_flight;
  logic [1:0]        out_leds;
  logic              out_console;
  logic              out_tele;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] line_char;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      id_state     <= 8'd1;
      id_led_a     <= 8'd2;
      id_led_b     <= 8'd3;
      id_console   <= 8'd4;
      id_telemetry <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ID_STATE:     id_state     <= cfg_data;
        CFG_ID_LED_A:     id_led_a     <= cfg_data;
        CFG_ID_LED_B:     id_led_b     <= cfg_data;
        CFG_ID_CONSOLE:   id_console   <= cfg_data;
        CFG_ID_TELEMETRY: id_telemetry <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register is free.
  assign s1_adv        = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_mode <= s_axis_tuser;
      s1_byte <= s_axis_tdata[7:0];
      s1_ridx <= s_axis_tdata[13:8];
    end
  end

  // Common decode for both combinational blocks.
  assign frame_word   = (s1_mode == MODE_RX) && !console_mode;
  assign console_word = (s1_mode == MODE_RX) && console_mode;
  assign line_base    = line_done ? '0 : line_count;
  assign payload_dec  = payload_left - 8'd1;

  // Next state of the frame receiver and the console line.
  always_comb begin
    phase_next         = phase;
    current_id_next    = current_id;
    payload_left_next  = payload_left;
    first_payload_next = first_payload;
    has_payload_next   = has_payload;
    flight_value_next  = flight_value;
    led_levels_next    = led_levels;
    console_mode_next  = console_mode;
    line_count_next    = line_count;
    line_done_next     = line_done;
    wr_en              = 1'b0;
    if (frame_word) begin
      unique case (phase)
        PH_SYNC1: begin
          if (s1_byte == SYNC_A) begin
            phase_next = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          phase_next = (s1_byte == SYNC_B) ? PH_ID : PH_SYNC1;
        end
        PH_ID: begin
          current_id_next = s1_byte;
          phase_next      = PH_LEN;
        end
        PH_LEN: begin
          payload_left_next = s1_byte;
          has_payload_next  = (s1_byte != 8'd0);
          phase_next        = (s1_byte != 8'd0) ? PH_PAY_FIRST : PH_TRAILER;
        end
        PH_PAY_FIRST, PH_PAY_REST: begin
          if (phase == PH_PAY_FIRST) begin
            first_payload_next = s1_byte;
          end
          payload_left_next = payload_dec;
          phase_next        = (payload_dec == 8'd0) ? PH_TRAILER : PH_PAY_REST;
        end
        PH_TRAILER: begin
          phase_next = PH_SYNC1;
          priority if (current_id == id_state) begin
            if (has_payload) begin
              flight_value_next = first_payload;
            end
          end else if (current_id == id_led_a) begin
            led_levels_next[0] = ~led_levels[0];
          end else if (current_id == id_led_b) begin
            led_levels_next[1] = ~led_levels[1];
          end else if (current_id == id_console) begin
            console_mode_next = 1'b1;
          end else begin
            // Telemetry and unknown ids change no state.
          end
        end
        default: begin
          phase_next = PH_SYNC1;
        end
      endcase
    end else if (console_word) begin
      // A finished line is emptied by the next console byte of any kind.
      line_count_next = line_base;
      line_done_next  = 1'b0;
      priority if (s1_byte == CH_CR) begin
        line_done_next = 1'b1;
      end else if (s1_byte == CH_BS) begin
        if (line_base != '0) begin
          line_count_next = line_base - CNT_W'(1);
        end
      end else if (line_base != FULL_CNT) begin
        wr_en           = 1'b1;
        line_count_next = line_base + CNT_W'(1);
      end else begin
        // A full line drops the character.
      end
    end else if ((s1_mode == MODE_LEAVE) && console_mode) begin
      console_mode_next = 1'b0;
      phase_next        = PH_SYNC1;
    end
  end

  // Event, echo and telemetry pulse of the current word.
  always_comb begin
    ev   = EV_NONE;
    tele = 1'b0;
    echo = '0;
    if (frame_word) begin
      if (phase == PH_TRAILER) begin
        ev = EV_FRAME;
        priority if ((current_id == id_state) || (current_id == id_led_a) ||
                     (current_id == id_led_b)) begin
          ev = EV_FRAME;
        end else if (current_id == id_console) begin
          ev = EV_CONSOLE;
        end else if (current_id == id_telemetry) begin
          tele = 1'b1;
        end else begin
          // Any other id only completes the frame.
        end
      end
    end else if (console_word) begin
      priority if (s1_byte == CH_CR) begin
        ev = EV_LINE;
      end else if (s1_byte == CH_BS) begin
        ev   = EV_ECHO;
        echo = s1_byte;
      end else if (line_base == FULL_CNT) begin
        ev = EV_OVERFLOW;
      end else begin
        ev   = EV_ECHO;
        echo = s1_byte;
      end
    end
  end

  // State registers, updated as each word passes the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC1;
      current_id    <= '0;
      payload_left  <= '0;
      first_payload <= '0;
      has_payload   <= 1'b0;
      flight_value  <= '0;
      led_levels    <= '0;
      console_mode  <= 1'b0;
      line_count    <= '0;
      line_done     <= 1'b0;
    end else if (s1_adv) begin
      phase         <= phase_next;
      current_id    <= current_id_next;
      payload_left  <= payload_left_next;
      first_payload <= first_payload_next;
      has_payload   <= has_payload_next;
      flight_value  <= flight_value_next;
      led_levels    <= led_levels_next;
      console_mode  <= console_mode_next;
      line_count    <= line_count_next;
      line_done     <= line_done_next;
    end
  end

  // Console line store with registered read at the requested position.
  slfr_line_mem #(
    .DEPTH (LINE_DEPTH),
    .IDX_W (IDX_W)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (wr_en && s1_adv),
    .wr_addr (line_base[IDX_W-1:0]),
    .wr_data (s1_byte),
    .rd_en   (s1_adv),
    .rd_addr (IDX_W'(s1_ridx)),
    .rd_data (rd_data)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ev      <= ev;
      out_msg     <= (ev == EV_FRAME) ? current_id : '0;
      out_echo    <= echo;
      out_len     <= LEN_W'(line_count_next);
      out_char_ok <= CMP_W'(s1_ridx) < CMP_W'(line_count_next);
      out_flight  <= flight_value_next;
      out_leds    <= led_levels_next;
      out_console <= console_mode_next;
      out_tele    <= tele;
    end
  end

  // Positions at or beyond the line length read as zero.
  assign line_char    = out_char_ok ? rd_data : '0;
  assign m_axis_tuser = out_ev;
  assign m_axis_tdata = {5'd0, out_tele, out_console, out_leds[1], out_leds[0],
                         out_flight, line_char, out_len, out_echo, out_msg};

  // The line never holds more than its capacity.
  assert property (@(posedge clk) disable iff (rst) line_count <= FULL_CNT)
    else $error("line count above capacity");

  // Only a completed frame carries a message id.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_ev != EV_FRAME) |-> (out_msg == '0))
    else $error("message id without frame event");

  // A telemetry pulse only comes with a frame event.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_tele |-> (out_ev == EV_FRAME))
    else $error("telemetry pulse without frame event");

  // Entering the console shows console mode in the same result.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_ev == EV_CONSOLE) |-> out_console)
    else $error("console event without console mode");

  // A word held in the input register is not lost while the output stalls.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("input word dropped during stall");

endmodule

`default_nettype wire
